[hw/rtl/pf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pf_pkg
// Shared types, letter codes and square geometry for the Playfair encryptor.
// ----------------------------------------------------------------------------
package pf_pkg;

  localparam int GRID_SIDE = 5;
  localparam int CELLS     = GRID_SIDE * GRID_SIDE;
  localparam int LETTERS   = 26;
  localparam int CODE_W    = 5;
  localparam int IDX_W     = $clog2(CELLS);
  localparam int RC_W      = $clog2(GRID_SIDE);

  localparam logic [CODE_W-1:0] CODE_I = CODE_W'(8);
  localparam logic [CODE_W-1:0] CODE_J = CODE_W'(9);
  localparam logic [CODE_W-1:0] CODE_X = CODE_W'(23);

  typedef enum logic [1:0] {
    OP_KEY     = 2'd0,
    OP_KEY_END = 2'd1,
    OP_TEXT    = 2'd2,
    OP_MSG_END = 2'd3
  } op_t;

  // Row of a cell index, by compare against each row start
  function automatic logic [RC_W-1:0] cell_row(logic [IDX_W-1:0] p);
    logic [RC_W-1:0] r;
    r = '0;
    for (int k = 1; k < GRID_SIDE; k++) begin
      if (p >= IDX_W'(k * GRID_SIDE)) r = RC_W'(k);
    end
    return r;
  endfunction

  function automatic logic [RC_W-1:0] cell_col(logic [IDX_W-1:0] p);
    logic [IDX_W-1:0] base;
    base = IDX_W'(cell_row(p)) * IDX_W'(GRID_SIDE);
    return RC_W'(p - base);
  endfunction

  function automatic logic [IDX_W-1:0] cell_index(logic [RC_W-1:0] r, logic [RC_W-1:0] c);
    return IDX_W'(r) * IDX_W'(GRID_SIDE) + IDX_W'(c);
  endfunction

  function automatic logic [RC_W-1:0] wrap_inc(logic [RC_W-1:0] v);
    return (v == RC_W'(GRID_SIDE - 1)) ? '0 : RC_W'(v + RC_W'(1));
  endfunction

endpackage

[hw/rtl/pf_pair_rule.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pf_pair_rule
// Maps the cells of a letter pair to the cells of its cipher pair:
// same row shifts right, same column shifts down, else rectangle swap.
// ----------------------------------------------------------------------------
module pf_pair_rule (
  input  logic [pf_pkg::IDX_W-1:0] p1,
  input  logic [pf_pkg::IDX_W-1:0] p2,
  output logic [pf_pkg::IDX_W-1:0] n1,
  output logic [pf_pkg::IDX_W-1:0] n2
);

  logic [pf_pkg::RC_W-1:0] r1, c1, r2, c2;

  assign r1 = pf_pkg::cell_row(p1);
  assign c1 = pf_pkg::cell_col(p1);
  assign r2 = pf_pkg::cell_row(p2);
  assign c2 = pf_pkg::cell_col(p2);

  always_comb begin
    if (r1 == r2) begin
      n1 = pf_pkg::cell_index(r1, pf_pkg::wrap_inc(c1));
      n2 = pf_pkg::cell_index(r2, pf_pkg::wrap_inc(c2));
    end else if (c1 == c2) begin
      n1 = pf_pkg::cell_index(pf_pkg::wrap_inc(r1), c1);
      n2 = pf_pkg::cell_index(pf_pkg::wrap_inc(r2), c2);
    end else begin
      n1 = pf_pkg::cell_index(r1, c2);
      n2 = pf_pkg::cell_index(r2, c1);
    end
  end

endmodule

[hw/rtl/playfair_encryptor_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// playfair_encryptor_core
// Builds a 5x5 Playfair square from key letters and enciphers a letter
// stream pair by pair.
//
//   channel | ports                                         | direction
//   --------+-----------------------------------------------+----------
//   in      | in_valid, in_stall, in_operation, in_letter   | request in
//   out     | out_valid, out_stall, out_cipher_letter,      | request out
//           | out_last_in_run, out_message_done             |
//
// Key letter, plaintext letter without a pair and end of message with
// nothing pending are handled in S_IDLE. End of key walks the alphabet in S_FILL.
// A completed pair walks S_RD_A, S_RD_B, S_CALC, S_SQ_A and S_SQ_B (one read
// port each on the position and square memories); S_OUT_A, S_OUT_B hand out.
// Reset clears control state and the used-letter mask; the memories keep
// their contents. in_stall stays high until both cipher letters are taken.
// ----------------------------------------------------------------------------
module playfair_encryptor_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_operation,
  input  logic [pf_pkg::CODE_W-1:0] in_letter,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [pf_pkg::CODE_W-1:0] out_cipher_letter,
  output logic                      out_last_in_run,
  output logic                      out_message_done
);

  typedef enum logic [3:0] {
    S_IDLE, S_FILL, S_RD_A, S_RD_B, S_CALC, S_SQ_A, S_SQ_B, S_OUT_A, S_OUT_B
  } state_t;

  localparam int CW = pf_pkg::CODE_W;
  localparam int IW = pf_pkg::IDX_W;

  state_t                  state_r, state_nxt;
  logic [pf_pkg::LETTERS-1:0] used_r, used_nxt;
  logic [IW:0]             fill_r, fill_nxt;
  logic [CW-1:0]           walk_r, walk_nxt;
  logic [CW-1:0]           pend_r, pend_nxt;
  logic                    pend_vld_r, pend_vld_nxt;
  logic [CW-1:0]           prev_r, prev_nxt;
  logic                    prev_vld_r, prev_vld_nxt;
  logic [CW-1:0]           a_r, a_nxt, b_r, b_nxt;
  logic                    done_r, done_nxt;
  logic [IW-1:0]           p1_r, p1_nxt, n1_r, n1_nxt, n2_r, n2_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [CW-1:0]           out_cl_r, out_cl_nxt;
  logic                    out_last_r, out_last_nxt;
  logic                    out_done_r, out_done_nxt;

  // Memories: one write port, one registered read port each
  logic [CW-1:0] sq_mem [pf_pkg::CELLS];
  logic [IW-1:0] lp_mem [pf_pkg::LETTERS];
  logic [IW-1:0] lp_q_r;
  logic [CW-1:0] sq_q_r;
  logic          wr_en;
  logic [CW-1:0] wr_code;
  logic [CW-1:0] lp_raddr;
  logic [IW-1:0] sq_raddr;
  logic [IW-1:0] rule_n1, rule_n2;

  logic          in_acc, out_acc;
  logic          code_ok;
  logic [CW-1:0] key_code;
  logic          place_ok;
  logic          repeat_hit;

  function automatic logic [CW-1:0] fold_j(logic [CW-1:0] c);
    return (c == pf_pkg::CODE_J) ? pf_pkg::CODE_I : c;
  endfunction

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid_r && !out_stall;
  assign code_ok  = (in_letter < CW'(pf_pkg::LETTERS));
  assign key_code = (state_r == S_FILL) ? walk_r : fold_j(in_letter);
  assign wr_code  = key_code;
  assign repeat_hit = prev_vld_r && (prev_r == in_letter);

  always_comb begin
    place_ok = 1'b0;
    if (fill_r < (IW + 1)'(pf_pkg::CELLS) && key_code < CW'(pf_pkg::LETTERS)) begin
      place_ok = !used_r[key_code];
    end
  end

  always_comb begin
    wr_en = 1'b0;
    if (state_r == S_FILL) begin
      wr_en = place_ok && (walk_r != pf_pkg::CODE_J);
    end else if (in_acc && pf_pkg::op_t'(in_operation) == pf_pkg::OP_KEY) begin
      wr_en = place_ok && code_ok;
    end
  end

  always_comb begin
    lp_raddr = fold_j(b_r);
    if (state_r == S_RD_A) lp_raddr = fold_j(a_r);
    sq_raddr = n2_r;
    if (state_r == S_SQ_A) sq_raddr = n1_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      sq_mem[fill_r[IW-1:0]] <= wr_code;
      lp_mem[wr_code]        <= fill_r[IW-1:0];
    end
    lp_q_r <= lp_mem[lp_raddr];
    sq_q_r <= sq_mem[sq_raddr];
  end

  pf_pair_rule u_rule (
    .p1 (p1_r),
    .p2 (lp_q_r),
    .n1 (rule_n1),
    .n2 (rule_n2)
  );

  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    fill_nxt      = fill_r;
    walk_nxt      = walk_r;
    pend_nxt      = pend_r;
    pend_vld_nxt  = pend_vld_r;
    prev_nxt      = prev_r;
    prev_vld_nxt  = prev_vld_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    done_nxt      = done_r;
    p1_nxt        = p1_r;
    n1_nxt        = n1_r;
    n2_nxt        = n2_r;
    out_valid_nxt = out_valid_r;
    out_cl_nxt    = out_cl_r;
    out_last_nxt  = out_last_r;
    out_done_nxt  = out_done_r;

    if (wr_en) begin
      used_nxt[wr_code] = 1'b1;
      fill_nxt          = fill_r + (IW + 1)'(1);
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (pf_pkg::op_t'(in_operation))
            pf_pkg::OP_KEY: begin
            end
            pf_pkg::OP_KEY_END: begin
              walk_nxt  = '0;
              state_nxt = S_FILL;
            end
            pf_pkg::OP_TEXT: begin
              if (code_ok) begin
                prev_nxt     = in_letter;
                prev_vld_nxt = 1'b1;
                done_nxt     = 1'b0;
                if (repeat_hit) begin
                  // insert X between the repeated letters
                  if (pend_vld_r) begin
                    a_nxt        = pend_r;
                    b_nxt        = pf_pkg::CODE_X;
                    pend_nxt     = in_letter;
                    pend_vld_nxt = 1'b1;
                  end else begin
                    a_nxt        = pf_pkg::CODE_X;
                    b_nxt        = in_letter;
                    pend_vld_nxt = 1'b0;
                  end
                  state_nxt = S_RD_A;
                end else if (pend_vld_r) begin
                  a_nxt        = pend_r;
                  b_nxt        = in_letter;
                  pend_vld_nxt = 1'b0;
                  state_nxt    = S_RD_A;
                end else begin
                  pend_nxt     = in_letter;
                  pend_vld_nxt = 1'b1;
                end
              end
            end
            pf_pkg::OP_MSG_END: begin
              prev_vld_nxt = 1'b0;
              if (pend_vld_r) begin
                a_nxt        = pend_r;
                b_nxt        = pf_pkg::CODE_X;
                done_nxt     = 1'b1;
                pend_vld_nxt = 1'b0;
                state_nxt    = S_RD_A;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_FILL: begin
        walk_nxt = walk_r + CW'(1);
        if (walk_r == CW'(pf_pkg::LETTERS - 1)) state_nxt = S_IDLE;
      end
      S_RD_A: state_nxt = S_RD_B;
      S_RD_B: begin
        p1_nxt    = lp_q_r;
        state_nxt = S_CALC;
      end
      S_CALC: begin
        n1_nxt    = rule_n1;
        n2_nxt    = rule_n2;
        state_nxt = S_SQ_A;
      end
      S_SQ_A: state_nxt = S_SQ_B;
      S_SQ_B: begin
        out_valid_nxt = 1'b1;
        out_cl_nxt    = sq_q_r;
        out_last_nxt  = 1'b0;
        out_done_nxt  = 1'b0;
        state_nxt     = S_OUT_A;
      end
      S_OUT_A: begin
        // sq_q_r holds the second cipher letter while the first waits
        if (out_acc) begin
          out_cl_nxt   = sq_q_r;
          out_last_nxt = 1'b1;
          out_done_nxt = done_r;
          state_nxt    = S_OUT_B;
        end
      end
      S_OUT_B: begin
        if (out_acc) begin
          out_valid_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      fill_r      <= '0;
      walk_r      <= '0;
      pend_r      <= '0;
      pend_vld_r  <= 1'b0;
      prev_r      <= '0;
      prev_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      fill_r      <= fill_nxt;
      walk_r      <= walk_nxt;
      pend_r      <= pend_nxt;
      pend_vld_r  <= pend_vld_nxt;
      prev_r      <= prev_nxt;
      prev_vld_r  <= prev_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    done_r     <= done_nxt;
    p1_r       <= p1_nxt;
    n1_r       <= n1_nxt;
    n2_r       <= n2_nxt;
    out_cl_r   <= out_cl_nxt;
    out_last_r <= out_last_nxt;
    out_done_r <= out_done_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_cipher_letter = out_cl_r;
  assign out_last_in_run   = out_last_r;
  assign out_message_done  = out_done_r;

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for playfair_encryptor_core. It builds one square from a
// partly random key, then streams plaintext letters and message ends with
// random stalls and gaps on both channels. A scoreboard keeps its own square
// and pairing state and compares every cipher letter with the queued
// prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import pf_pkg::*;

  typedef struct packed {
    logic [CODE_W-1:0] letter;
    logic              last;
    logic              done;
  } cipher_t;

  class cipher_scoreboard;
    logic [CODE_W-1:0]  grid [CELLS];
    int unsigned        where [LETTERS];
    logic [LETTERS-1:0] taken;
    int unsigned        filled;
    logic [CODE_W-1:0]  held_letter;
    bit                 held;
    logic [CODE_W-1:0]  prior_plain;
    bit                 prior_ok;
    cipher_t            cipher_q [$];
    int unsigned        errors;

    function new();
      taken       = '0;
      filled      = 0;
      held_letter = '0;
      held        = 1'b0;
      prior_plain = '0;
      prior_ok    = 1'b0;
      errors      = 0;
    endfunction

    function int outstanding();
      return cipher_q.size();
    endfunction

    function void place(logic [CODE_W-1:0] code);
      if (filled >= CELLS || code >= LETTERS || taken[code]) return;
      grid[filled] = code;
      where[code]  = filled;
      taken[code]  = 1'b1;
      filled++;
    endfunction

    // Encipher one pair; the second letter closes the request.
    function void encipher_pair(logic [CODE_W-1:0] a, logic [CODE_W-1:0] b, bit done);
      int unsigned pa, pb, ra, ca, rb, cb, na, nb;
      pa = where[(a == CODE_J) ? CODE_I : a];
      pb = where[(b == CODE_J) ? CODE_I : b];
      ra = pa / GRID_SIDE;
      ca = pa % GRID_SIDE;
      rb = pb / GRID_SIDE;
      cb = pb % GRID_SIDE;
      if (ra == rb) begin
        na = ra * GRID_SIDE + (ca + 1) % GRID_SIDE;
        nb = rb * GRID_SIDE + (cb + 1) % GRID_SIDE;
      end else if (ca == cb) begin
        na = ((ra + 1) % GRID_SIDE) * GRID_SIDE + ca;
        nb = ((rb + 1) % GRID_SIDE) * GRID_SIDE + cb;
      end else begin
        na = ra * GRID_SIDE + cb;
        nb = rb * GRID_SIDE + ca;
      end
      cipher_q.push_back(cipher_t'{grid[na], 1'b0, 1'b0});
      cipher_q.push_back(cipher_t'{grid[nb], 1'b1, done});
    endfunction

    function void feed(logic [CODE_W-1:0] code);
      if (held) begin
        held = 1'b0;
        encipher_pair(held_letter, code, 1'b0);
      end else begin
        held_letter = code;
        held        = 1'b1;
      end
    endfunction

    function void note_request(op_t op, logic [CODE_W-1:0] code);
      case (op)
        OP_KEY: begin
          if (code < LETTERS) place((code == CODE_J) ? CODE_I : code);
        end
        OP_KEY_END: begin
          for (int k = 0; k < LETTERS; k++)
            if (CODE_W'(k) != CODE_J) place(CODE_W'(k));
        end
        OP_TEXT: begin
          if (code < LETTERS) begin
            // doubled letter: split it with an X, compared before J folds
            if (prior_ok && prior_plain == code) feed(CODE_X);
            feed(code);
            prior_plain = code;
            prior_ok    = 1'b1;
          end
        end
        default: begin
          if (held) begin
            held = 1'b0;
            encipher_pair(held_letter, CODE_X, 1'b1);
          end
          prior_ok = 1'b0;
        end
      endcase
    endfunction

    function void check_cipher(logic [CODE_W-1:0] letter, logic last, logic done);
      cipher_t want;
      if (cipher_q.size() == 0) begin
        $error("unexpected result: cipher_letter %0d", letter);
        errors++;
        return;
      end
      want = cipher_q.pop_front();
      if (letter !== want.letter) begin
        $error("cipher_letter: expected %0d, actual %0d", want.letter, letter);
        errors++;
      end
      if (last !== want.last) begin
        $error("last_in_run: expected %0b, actual %0b", want.last, last);
        errors++;
      end
      if (done !== want.done) begin
        $error("message_done: expected %0b, actual %0b", want.done, done);
        errors++;
      end
    endfunction
  endclass

  localparam int unsigned CYCLE_LIMIT = 300000;

  logic              clk          = 1'b0;
  logic              rst_n        = 1'b0;
  logic              in_valid     = 1'b0;
  logic              in_stall;
  logic [1:0]        in_operation = OP_KEY;
  logic [CODE_W-1:0] in_letter    = '0;
  logic              out_valid;
  logic              out_stall    = 1'b0;
  logic [CODE_W-1:0] out_cipher_letter;
  logic              out_last_in_run;
  logic              out_message_done;

  bit                in_gaps_on    = 1'b1;
  bit                out_gaps_on   = 1'b1;
  bit                long_hold_req = 1'b0;
  logic [CODE_W-1:0] recent_plain  = '0;
  int unsigned       cycle_count   = 0;

  cipher_scoreboard sb = new();

  playfair_encryptor_core uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_letter         (in_letter),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_cipher_letter (out_cipher_letter),
    .out_last_in_run   (out_last_in_run),
    .out_message_done  (out_message_done)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_cipher(out_cipher_letter, out_last_in_run, out_message_done);
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin : receiver_stall
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = 600;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (out_gaps_on) begin
        out_stall <= ($urandom_range(99) < 33);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one request, idling first at random; return at the accepting edge.
  task automatic send_request(op_t op, logic [CODE_W-1:0] code);
    if (in_gaps_on) begin
      while ($urandom_range(99) < 33) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_letter    <= code;
    do @(posedge clk); while (in_stall);
    sb.note_request(op, code);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // Mostly plaintext with many doubled letters, J/I and X, some message ends,
  // and a little noise that the finished square ignores.
  task automatic random_text(int unsigned count);
    int unsigned       sent;
    int unsigned       roll;
    logic [CODE_W-1:0] code;
    sent = 0;
    while (sent < count) begin
      roll = $urandom_range(99);
      if (roll < 4) begin
        case ($urandom_range(2))
          0:       send_request(OP_KEY, CODE_W'($urandom_range(31)));
          1:       send_request(OP_KEY_END, CODE_W'($urandom_range(31)));
          default: send_request(OP_TEXT, CODE_W'($urandom_range(31, LETTERS)));
        endcase
      end else if (roll < 14) begin
        send_request(OP_MSG_END, CODE_W'($urandom_range(31)));
        sent++;
      end else begin
        roll = $urandom_range(99);
        if (roll < 30)      code = recent_plain;
        else if (roll < 40) code = $urandom_range(1) ? CODE_J : CODE_I;
        else if (roll < 48) code = CODE_X;
        else                code = CODE_W'($urandom_range(LETTERS - 1));
        send_request(OP_TEXT, code);
        recent_plain = code;
        sent++;
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Key phase: folding, repeats, out-of-range codes, then completion.
    send_request(OP_MSG_END, '0);
    send_request(OP_KEY, 5'd10);
    send_request(OP_KEY, CODE_J);
    send_request(OP_KEY, CODE_I);
    send_request(OP_KEY, 5'd31);
    send_request(OP_KEY, 5'd26);
    send_request(OP_KEY, 5'd25);
    send_request(OP_KEY, CODE_W'($urandom_range(LETTERS - 1)));
    send_request(OP_KEY, CODE_W'($urandom_range(LETTERS - 1)));
    send_request(OP_KEY_END, '0);
    send_request(OP_KEY_END, 5'd31);
    send_request(OP_KEY, 5'd0);

    // Plaintext: extremes, doubled letters on both pair phases, J against I,
    // an ignored code, padding and an empty message end.
    send_request(OP_TEXT, 5'd0);
    send_request(OP_TEXT, 5'd25);
    send_request(OP_TEXT, CODE_J);
    send_request(OP_TEXT, CODE_J);
    send_request(OP_TEXT, CODE_I);
    send_request(OP_TEXT, 5'd1);
    send_request(OP_TEXT, 5'd2);
    send_request(OP_TEXT, 5'd2);
    send_request(OP_TEXT, 5'd31);
    send_request(OP_TEXT, 5'd16);
    send_request(OP_MSG_END, '0);
    send_request(OP_MSG_END, 5'd31);
    recent_plain = 5'd16;

    random_text(150);
    long_hold_req = 1'b1;
    random_text(150);
    in_gaps_on  = 1'b0;
    out_gaps_on = 1'b0;
    random_text(150);
    in_gaps_on  = 1'b1;
    out_gaps_on = 1'b1;
    wait_drained();
    random_text(250);

    wait_drained();
    repeat (40) @(posedge clk);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[playfair_encryptor_core.f]
hw/rtl/pf_pkg.sv
hw/rtl/pf_pair_rule.sv
hw/rtl/playfair_encryptor_core.sv
test/tb_top.sv
